### hdl/dde_pkg.sv
`timescale 1ns / 1ps

package dde_pkg;

  localparam int PIX_W      = 8;
  localparam int THR_W      = 8;
  localparam int CFG_WIDTH_W  = 9;
  localparam int CFG_HEIGHT_W = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  // Smallest frame dimension the scan logic accepts.
  localparam int MIN_DIM = 3;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd2;

  localparam logic [THR_W-1:0]        RST_THRESHOLD = 8'd1;
  localparam logic [CFG_WIDTH_W-1:0]  RST_WIDTH     = 9'd256;
  localparam logic [CFG_HEIGHT_W-1:0] RST_HEIGHT    = 13'd256;

  typedef logic [PIX_W-1:0] pix_t;

  // Per-item position flags, worked out when the item is accepted.
  typedef struct packed {
    logic valid;      // pipeline has filled
    logic interior;   // centre pixel lies off every frame border
    logic frame_end;  // centre pixel is the last one of its frame
  } pos_flags_t;

endpackage

### hdl/dde_ram.sv
`timescale 1ns / 1ps

module dde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/dde_scan.sv
`timescale 1ns / 1ps

module dde_scan #(
  parameter int MAX_WIDTH  = dde_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = dde_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  logic [dde_pkg::CFG_WIDTH_W-1:0]   image_width,
  input  logic [dde_pkg::CFG_HEIGHT_W-1:0]  image_height,
  output logic [$clog2(MAX_WIDTH)-1:0]      col,
  output dde_pkg::pos_flags_t               flags
);

  import dde_pkg::*;

  localparam int COLW     = $clog2(MAX_WIDTH);
  localparam int ROWW     = $clog2(MAX_HEIGHT);
  localparam int WCW      = $clog2(MAX_WIDTH + 2);
  localparam int HCW      = $clog2(MAX_HEIGHT + 1);
  localparam int FILL_MAX = MAX_WIDTH + 1;

  logic [COLW-1:0] col_r, col_nxt, col_c;
  logic [ROWW-1:0] row_r, row_nxt, row_c;
  logic [WCW-1:0]  fill_r, fill_nxt;
  logic [WCW-1:0]  w_eff, col_inc;
  logic [HCW-1:0]  h_eff, row_inc;

  // Clamp the geometry between MIN_DIM and MAX_WIDTH (the line-store depth) / MAX_HEIGHT.
  always_comb begin
    if (int'(image_width) < MIN_DIM) begin
      w_eff = WCW'(MIN_DIM);
    end else if (int'(image_width) > MAX_WIDTH) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = WCW'(image_width);
    end
    if (int'(image_height) < MIN_DIM) begin
      h_eff = HCW'(MIN_DIM);
    end else if (int'(image_height) > MAX_HEIGHT) begin
      h_eff = HCW'(MAX_HEIGHT);
    end else begin
      h_eff = HCW'(image_height);
    end
  end

  // A position left beyond a smaller geometry restarts at zero.
  always_comb begin
    col_c = (WCW'(col_r) >= w_eff) ? '0 : col_r;
    row_c = (HCW'(row_r) >= h_eff) ? '0 : row_r;
  end

  always_comb begin
    col_inc = WCW'(col_c) + WCW'(1);
    row_inc = HCW'(row_c) + HCW'(1);
    col_nxt = col_c;
    row_nxt = row_c;
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= h_eff) ? '0 : row_inc[ROWW-1:0];
    end else begin
      col_nxt = col_inc[COLW-1:0];
    end
    fill_nxt = (int'(fill_r) < FILL_MAX) ? fill_r + WCW'(1) : fill_r;
  end

  always_comb begin
    flags.valid     = fill_r >= (w_eff + WCW'(1));
    flags.interior  = flags.valid && (col_c >= COLW'(2)) && (row_c >= ROWW'(2));
    flags.frame_end = flags.valid && (col_c == '0) && (row_c == ROWW'(1));
  end

  assign col = col_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      fill_r <= '0;
    end else if (step) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

### hdl/dde_window.sv
`timescale 1ns / 1ps

module dde_window (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     shift,
  input  dde_pkg::pix_t            up,
  input  dde_pkg::pix_t            mid,
  input  dde_pkg::pix_t            px,
  input  logic [dde_pkg::THR_W-1:0] threshold,
  output dde_pkg::pix_t            centre,
  output logic                     edge_hit
);

  import dde_pkg::*;

  // Only the left and middle columns are kept; the right column of the
  // window seen by the decision is the live input (up, mid, px).
  pix_t win_r [3][2];
  pix_t diag [4];
  pix_t diff [4];
  logic [3:0] over;

  function automatic pix_t abs_diff(input pix_t a, input pix_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  always_comb begin
    centre  = win_r[1][1];
    diag[0] = win_r[0][0];
    diag[1] = up;
    diag[2] = win_r[2][0];
    diag[3] = px;
    for (int i = 0; i < 4; i++) begin
      diff[i] = abs_diff(centre, diag[i]);
      over[i] = diff[i] > threshold;
    end
    // An edge needs two differences over the threshold that are not equal.
    edge_hit = 1'b0;
    for (int i = 0; i < 4; i++) begin
      for (int j = i + 1; j < 4; j++) begin
        if (over[i] && over[j] && (diff[i] != diff[j])) begin
          edge_hit = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= '0;
        win_r[r][1] <= '0;
      end
    end else if (shift) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
      end
      win_r[0][1] <= up;
      win_r[1][1] <= mid;
      win_r[2][1] <= px;
    end
  end

endmodule

### hdl/diagonal_difference_edge_marker.sv
`timescale 1ns / 1ps

// Diagonal difference edge marker. Grey pixels enter in raster order, one item
// per clock unless in_stall holds them off, frames back to back, and every
// input item yields one result item for the pixel one row and one column
// earlier: its grey level, an edge mark and a frame-end mark. A centre pixel
// is marked when at least two of its four diagonal neighbours differ from it
// by amounts above the threshold register that are not equal; border pixels
// are never marked. The sustained rate is one item per clock while out_stall
// is low. The two line-store RAMs are read as an item enters the read stage;
// as it leaves, the window shifts and the output register takes the decision.
// The line stores are two RAMs of MAX_WIDTH x 8 bits, read at the incoming
// column and written back there as the item leaves the read stage. They need
// no clearing after reset; out_out_valid stays low until image_width + 1 items
// have been taken, and until then the other result fields are zero.
// Configuration may only be written while no item is in flight.
module diagonal_difference_edge_marker #(
  parameter int MAX_WIDTH  = dde_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = dde_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_write_en,
  input  logic [dde_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dde_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  dde_pkg::pix_t                   in_pixel_gray,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_out_valid,
  output dde_pkg::pix_t                   out_gray,
  output logic                            out_edge,
  output logic                            out_frame_end
);

  import dde_pkg::*;

  localparam int COLW = $clog2(MAX_WIDTH);

  // Configuration registers.
  logic [THR_W-1:0]        thr_r;
  logic [CFG_WIDTH_W-1:0]  width_r;
  logic [CFG_HEIGHT_W-1:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= RST_THRESHOLD;
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_THRESHOLD: thr_r    <= cfg_wdata[THR_W-1:0];
        CFG_WIDTH:     width_r  <= cfg_wdata[CFG_WIDTH_W-1:0];
        CFG_HEIGHT:    height_r <= cfg_wdata[CFG_HEIGHT_W-1:0];
        default:       ;
      endcase
    end
  end

  // Handshake. The read stage holds one item while its RAM data arrive; the
  // output register holds one finished result. Both move together whenever
  // the result side is free, so an item may enter every clock.
  logic accept, out_ready, s1_fire;
  logic s1_v_r;
  logic out_valid_r;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_fire   = s1_v_r && out_ready;
  assign in_stall  = s1_v_r && !out_ready;
  assign accept    = in_valid && !in_stall;

  // Raster position and fill tracking.
  logic [COLW-1:0] scan_col;
  pos_flags_t      scan_flags;

  dde_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (accept),
    .image_width  (width_r),
    .image_height (height_r),
    .col          (scan_col),
    .flags        (scan_flags)
  );

  // Read stage.
  pix_t            s1_px_r;
  logic [COLW-1:0] s1_col_r;
  pos_flags_t      s1_flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r    <= in_pixel_gray;
      s1_col_r   <= scan_col;
      s1_flags_r <= scan_flags;
    end
  end

  // Line stores. Each is read when an item is taken and written back once,
  // when that item leaves the read stage. Consecutive items always sit at
  // different columns, so the write never meets a read of the same entry.
  pix_t up_q, mid_q;

  dde_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_upper_line (
    .clk     (clk),
    .wr_en   (s1_fire),
    .wr_addr (s1_col_r),
    .wr_data (mid_q),
    .rd_en   (accept),
    .rd_addr (scan_col),
    .rd_data (up_q)
  );

  dde_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_middle_line (
    .clk     (clk),
    .wr_en   (s1_fire),
    .wr_addr (s1_col_r),
    .wr_data (s1_px_r),
    .rd_en   (accept),
    .rd_addr (scan_col),
    .rd_data (mid_q)
  );

  // 3x3 window and diagonal decision.
  pix_t win_centre;
  logic win_edge;

  dde_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift     (s1_fire),
    .up        (up_q),
    .mid       (mid_q),
    .px        (s1_px_r),
    .threshold (thr_r),
    .centre    (win_centre),
    .edge_hit  (win_edge)
  );

  // Output register.
  logic out_ov_r, out_edge_r, out_fend_r;
  pix_t out_gray_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_ov_r   <= s1_flags_r.valid;
      out_gray_r <= s1_flags_r.valid ? win_centre : '0;
      out_edge_r <= s1_flags_r.interior && win_edge;
      out_fend_r <= s1_flags_r.frame_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_out_valid = out_ov_r;
  assign out_gray      = out_gray_r;
  assign out_edge      = out_edge_r;
  assign out_frame_end = out_fend_r;

`ifndef SYNTH
  // The input side is only held off while the read stage is occupied.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r)
    else $error("input stalled with an empty read stage");

  // A taken item always lands in the read stage.
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_v_r)
    else $error("accepted item missing from the read stage");

  // The last pixel of a frame sits on a border and is never marked.
  a_frame_end_no_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |-> !out_edge)
    else $error("frame-end pixel marked as edge");

  // Nothing is marked before the pipeline has filled.
  a_edge_needs_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_edge) |-> out_out_valid)
    else $error("edge marked before pipeline filled");
`endif

endmodule
